FILE: design/vna_pkg.sv
// ----------------------------------------------------------------------------
// vna_pkg
// Shared constants, command and status types for the vertex normal accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vna_pkg;

  localparam int unsigned MAX_VERTICES = 1024;
  localparam int unsigned SLOT_W       = 10;
  localparam int unsigned COORD_W      = 24;
  localparam int unsigned DIFF_W       = COORD_W + 1;
  localparam int unsigned ACC_W        = 64;
  localparam int unsigned NORM_W       = 16;
  localparam int unsigned MUL_W        = 33;
  localparam int unsigned Q_W          = 17;
  localparam int unsigned REM_W        = 51;
  localparam int unsigned LEN_W        = 33;
  localparam int unsigned MAG_W        = 31;
  localparam int unsigned IN_W         = 128;
  localparam int unsigned OUT_W        = 64;
  localparam int unsigned VTX_W        = 3 * COORD_W;
  localparam int unsigned ACCV_W       = 3 * ACC_W;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_TRI  = 2'd1;
  localparam logic [1:0] OP_QUAD = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLEAR,
    DP_CAPTURE,
    DP_LOAD,
    DP_VRD,
    DP_MUL,
    DP_ACC_WR,
    DP_RD_CAP,
    DP_SHIFT,
    DP_ZERO,
    DP_SQ,
    DP_SQRT,
    DP_DIV,
    DP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e            op;
    logic [5:0]        step;
    logic [1:0]        idx;
    logic [SLOT_W-1:0] addr;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       shift_done;
    logic       vec_zero;
    logic       out_busy;
  } dp_sts_t;

  function automatic logic signed [ACC_W-1:0] add_sat(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W-1:0] s;
    s = a + b;
    if ((a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1])) begin
      s = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s;
  endfunction

  function automatic logic [NORM_W-1:0] clamp_q15(input logic neg, input logic [Q_W-1:0] q);
    logic [Q_W-1:0] c;
    if (neg) begin
      c = (q > Q_W'(32768)) ? Q_W'(32768) : q;
      c = Q_W'(0) - c;
    end else begin
      c = (q > Q_W'(32767)) ? Q_W'(32767) : q;
    end
    return c[NORM_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: design/vna_ram.sv
// ----------------------------------------------------------------------------
// vna_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vna_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: design/vna_datapath.sv
// ----------------------------------------------------------------------------
// vna_datapath
// Vertex and accumulator stores, shared multiplier, square root and divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vna_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire vna_pkg::dp_cmd_t              cmd_i,
  output      vna_pkg::dp_sts_t              sts_o,
  input  wire logic [vna_pkg::IN_W-1:0]      in_data_i,
  input  wire logic [1:0]                    in_op_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [vna_pkg::OUT_W-1:0]     out_data_o
);

  localparam int unsigned CW = vna_pkg::COORD_W;
  localparam int unsigned DW = vna_pkg::DIFF_W;
  localparam int unsigned AW = vna_pkg::ACC_W;
  localparam int unsigned SW = vna_pkg::SLOT_W;
  localparam int unsigned MW = vna_pkg::MUL_W;
  localparam int unsigned RW = vna_pkg::REM_W;
  localparam int unsigned QW = vna_pkg::Q_W;
  localparam int unsigned NW = vna_pkg::NORM_W;

  logic [1:0]            op_q;
  logic [SW-1:0]         slot_q;
  logic signed [CW-1:0]  pos_q [3];
  logic [SW-1:0]         corner_q [4];
  logic signed [CW-1:0]  pa_q [3];
  logic signed [CW-1:0]  pb_q [3];
  logic signed [DW-1:0]  u_q [3];
  logic signed [DW-1:0]  v_q [3];
  logic signed [AW-1:0]  nrm_q [3];
  logic signed [AW-1:0]  prod_q;
  logic                  sgn_q [3];
  logic [AW-1:0]         mag_q [3];
  logic [AW-1:0]         n_q;
  logic [AW-1:0]         res_q;
  logic [AW-1:0]         bit_q;
  logic [RW-1:0]         rem_q;
  logic [RW-1:0]         dv_q;
  logic [QW-1:0]         quo_q;
  logic [NW-1:0]         nout_q [3];
  logic                  out_valid_q;
  logic [vna_pkg::OUT_W-1:0] out_data_q;

  logic [vna_pkg::VTX_W-1:0]  vtx_rd;
  logic [vna_pkg::ACCV_W-1:0] acc_rd;
  logic                       acc_we;
  logic [SW-1:0]              acc_waddr;
  logic [SW-1:0]              acc_raddr;
  logic [vna_pkg::ACCV_W-1:0] acc_wdata;
  logic signed [MW-1:0]       mul_a;
  logic signed [MW-1:0]       mul_b;
  logic signed [2*MW-1:0]     mul_p;
  logic [AW-1:0]              mag_or;
  logic [AW-1:0]              sq_t;
  logic [vna_pkg::LEN_W-1:0]  len;
  logic [vna_pkg::MAG_W-1:0]  div_r;
  logic                       div_ge;
  logic [QW-1:0]              quo_n;

  vna_ram #(.WIDTH(vna_pkg::VTX_W), .DEPTH(vna_pkg::MAX_VERTICES)) u_vtx_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.op == vna_pkg::DP_LOAD),
    .waddr_i (slot_q),
    .wdata_i ({pos_q[2], pos_q[1], pos_q[0]}),
    .raddr_i (corner_q[cmd_i.step[1:0]]),
    .rdata_o (vtx_rd)
  );

  always_comb begin
    acc_we    = 1'b0;
    acc_waddr = corner_q[cmd_i.idx];
    acc_wdata = '0;
    unique case (cmd_i.op)
      vna_pkg::DP_CLEAR: begin
        acc_we    = 1'b1;
        acc_waddr = cmd_i.addr;
      end
      vna_pkg::DP_LOAD: begin
        acc_we    = 1'b1;
        acc_waddr = slot_q;
      end
      vna_pkg::DP_ACC_WR: begin
        acc_we    = 1'b1;
        acc_wdata = {vna_pkg::add_sat(acc_rd[2*AW +: AW], nrm_q[2]),
                     vna_pkg::add_sat(acc_rd[AW +: AW], nrm_q[1]),
                     vna_pkg::add_sat(acc_rd[0 +: AW], nrm_q[0])};
      end
      default: ;
    endcase
  end

  assign acc_raddr = (op_q == vna_pkg::OP_READ) ? slot_q : corner_q[cmd_i.idx];

  vna_ram #(.WIDTH(vna_pkg::ACCV_W), .DEPTH(vna_pkg::MAX_VERTICES)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rd)
  );

  // shared multiplier: cross product terms, then squares
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.op == vna_pkg::DP_MUL) begin
      unique case (cmd_i.step[2:0])
        3'd0: begin mul_a = MW'(u_q[1]); mul_b = MW'(v_q[2]); end
        3'd1: begin mul_a = MW'(u_q[2]); mul_b = MW'(v_q[1]); end
        3'd2: begin mul_a = MW'(u_q[2]); mul_b = MW'(v_q[0]); end
        3'd3: begin mul_a = MW'(u_q[0]); mul_b = MW'(v_q[2]); end
        3'd4: begin mul_a = MW'(u_q[0]); mul_b = MW'(v_q[1]); end
        3'd5: begin mul_a = MW'(u_q[1]); mul_b = MW'(v_q[0]); end
        default: ;
      endcase
    end else if (cmd_i.op == vna_pkg::DP_SQ && cmd_i.step[1:0] != 2'd3) begin
      mul_a = $signed({2'b00, mag_q[cmd_i.step[1:0]][vna_pkg::MAG_W-1:0]});
      mul_b = mul_a;
    end
  end

  assign mul_p  = mul_a * mul_b;
  assign mag_or = mag_q[0] | mag_q[1] | mag_q[2];
  assign sq_t   = res_q + bit_q;
  assign len    = res_q[vna_pkg::LEN_W-1:0];
  assign div_r  = mag_q[cmd_i.idx][vna_pkg::MAG_W-1:0];
  assign div_ge = (rem_q >= dv_q);
  assign quo_n  = {quo_q[QW-2:0], div_ge};

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p[AW-1:0];
    unique case (cmd_i.op)
      vna_pkg::DP_CAPTURE: begin
        op_q        <= in_op_i;
        slot_q      <= in_data_i[9:0];
        pos_q[0]    <= in_data_i[33:10];
        pos_q[1]    <= in_data_i[57:34];
        pos_q[2]    <= in_data_i[81:58];
        corner_q[0] <= in_data_i[91:82];
        corner_q[1] <= in_data_i[101:92];
        corner_q[2] <= in_data_i[111:102];
        corner_q[3] <= in_data_i[121:112];
      end
      vna_pkg::DP_VRD: begin
        for (int i = 0; i < 3; i++) begin
          if (cmd_i.step[1:0] == 2'd1) pa_q[i] <= vtx_rd[CW*i +: CW];
          if (cmd_i.step[1:0] == 2'd2) pb_q[i] <= vtx_rd[CW*i +: CW];
          if (cmd_i.step[1:0] == 2'd3) begin
            u_q[i] <= DW'(pb_q[i]) - DW'(pa_q[i]);
            v_q[i] <= DW'($signed(vtx_rd[CW*i +: CW])) - DW'(pa_q[i]);
          end
        end
      end
      vna_pkg::DP_MUL: begin
        unique case (cmd_i.step[2:0])
          3'd1: nrm_q[0] <= prod_q;
          3'd2: nrm_q[0] <= nrm_q[0] - prod_q;
          3'd3: nrm_q[1] <= prod_q;
          3'd4: nrm_q[1] <= nrm_q[1] - prod_q;
          3'd5: nrm_q[2] <= prod_q;
          3'd6: nrm_q[2] <= nrm_q[2] - prod_q;
          default: ;
        endcase
      end
      vna_pkg::DP_RD_CAP: begin
        for (int i = 0; i < 3; i++) begin
          sgn_q[i] <= acc_rd[AW*i + AW - 1];
          mag_q[i] <= acc_rd[AW*i + AW - 1] ? (AW'(0) - acc_rd[AW*i +: AW])
                                             : acc_rd[AW*i +: AW];
        end
      end
      vna_pkg::DP_SHIFT: begin
        for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
      end
      vna_pkg::DP_SQ: begin
        unique case (cmd_i.step[1:0])
          2'd1: n_q <= prod_q;
          2'd2: n_q <= n_q + prod_q;
          2'd3: begin
            n_q   <= n_q + prod_q;
            res_q <= '0;
            bit_q <= {2'b01, {(AW-2){1'b0}}};
          end
          default: ;
        endcase
      end
      vna_pkg::DP_SQRT: begin
        if (n_q >= sq_t) begin
          n_q   <= n_q - sq_t;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      vna_pkg::DP_DIV: begin
        if (cmd_i.step == 6'd0) begin
          rem_q <= RW'({div_r, 16'h0000}) + RW'(len);
          dv_q  <= RW'({len, 17'h00000});
          quo_q <= '0;
        end else begin
          if (div_ge) rem_q <= rem_q - dv_q;
          dv_q  <= dv_q >> 1;
          quo_q <= quo_n;
          if (cmd_i.step == 6'd17) nout_q[cmd_i.idx] <= vna_pkg::clamp_q15(sgn_q[cmd_i.idx], quo_n);
        end
      end
      vna_pkg::DP_ZERO: begin
        for (int i = 0; i < 3; i++) nout_q[i] <= '0;
      end
      vna_pkg::DP_OUT: begin
        out_data_q <= {6'b000000, nout_q[2], nout_q[1], nout_q[0], slot_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == vna_pkg::DP_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;
  assign sts_o.op          = op_q;
  assign sts_o.shift_done  = (mag_or[AW-1:vna_pkg::MAG_W] == '0);
  assign sts_o.vec_zero    = (mag_or == '0);
  assign sts_o.out_busy    = out_valid_q;

endmodule

`default_nettype wire

FILE: design/vna_ctrl.sv
// ----------------------------------------------------------------------------
// vna_ctrl
// Sequencer: clearing pass, load, face accumulation and normalized read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vna_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [1:0]        in_op_i,
  output      logic              in_ready_o,
  output      vna_pkg::dp_cmd_t  cmd_o,
  input  wire vna_pkg::dp_sts_t  sts_i
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LOAD  = 4'd2;
  localparam logic [3:0] S_FRD   = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_DRD   = 4'd5;
  localparam logic [3:0] S_DWR   = 4'd6;
  localparam logic [3:0] S_RRD   = 4'd7;
  localparam logic [3:0] S_RCAP  = 4'd8;
  localparam logic [3:0] S_SHIFT = 4'd9;
  localparam logic [3:0] S_SQ    = 4'd10;
  localparam logic [3:0] S_SQRT  = 4'd11;
  localparam logic [3:0] S_DIV   = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  localparam logic [vna_pkg::SLOT_W-1:0] CLR_LAST = vna_pkg::SLOT_W'(vna_pkg::MAX_VERTICES - 1);

  logic [3:0]                 state_q, state_d;
  logic [vna_pkg::SLOT_W-1:0] cnt_q, cnt_d;
  logic [1:0]                 idx_q, idx_d;
  logic                       accept;
  logic [1:0]                 last_corner;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign last_corner = (sts_i.op == vna_pkg::OP_QUAD) ? 2'd3 : 2'd2;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    cmd_o.op   = vna_pkg::DP_NOP;
    cmd_o.step = cnt_q[5:0];
    cmd_o.idx  = idx_q;
    cmd_o.addr = cnt_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = vna_pkg::DP_CLEAR;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CLR_LAST) begin
          state_d = S_IDLE;
          cnt_d   = '0;
        end
      end
      S_IDLE: begin
        cnt_d = '0;
        idx_d = '0;
        if (accept) begin
          cmd_o.op = vna_pkg::DP_CAPTURE;
          unique case (in_op_i)
            vna_pkg::OP_LOAD: state_d = S_LOAD;
            vna_pkg::OP_TRI:  state_d = S_FRD;
            vna_pkg::OP_QUAD: state_d = S_FRD;
            vna_pkg::OP_READ: state_d = S_RRD;
            default:          state_d = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        cmd_o.op = vna_pkg::DP_LOAD;
        state_d  = S_IDLE;
      end
      S_FRD: begin
        cmd_o.op = vna_pkg::DP_VRD;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == 10'd3) begin
          state_d = S_MUL;
          cnt_d   = '0;
        end
      end
      S_MUL: begin
        cmd_o.op = vna_pkg::DP_MUL;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == 10'd6) begin
          state_d = S_DRD;
          cnt_d   = '0;
        end
      end
      S_DRD: begin
        state_d = S_DWR;
      end
      S_DWR: begin
        cmd_o.op = vna_pkg::DP_ACC_WR;
        if (idx_q == last_corner) begin
          state_d = S_IDLE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_DRD;
        end
      end
      S_RRD: begin
        state_d = S_RCAP;
      end
      S_RCAP: begin
        cmd_o.op = vna_pkg::DP_RD_CAP;
        state_d  = S_SHIFT;
      end
      S_SHIFT: begin
        if (!sts_i.shift_done) begin
          cmd_o.op = vna_pkg::DP_SHIFT;
        end else if (sts_i.vec_zero) begin
          cmd_o.op = vna_pkg::DP_ZERO;
          state_d  = S_DONE;
        end else begin
          state_d = S_SQ;
          cnt_d   = '0;
        end
      end
      S_SQ: begin
        cmd_o.op = vna_pkg::DP_SQ;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == 10'd3) begin
          state_d = S_SQRT;
          cnt_d   = '0;
        end
      end
      S_SQRT: begin
        cmd_o.op = vna_pkg::DP_SQRT;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == 10'd31) begin
          state_d = S_DIV;
          cnt_d   = '0;
          idx_d   = '0;
        end
      end
      S_DIV: begin
        cmd_o.op = vna_pkg::DP_DIV;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == 10'd17) begin
          cnt_d = '0;
          if (idx_q == 2'd2) begin
            state_d = S_DONE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.op = vna_pkg::DP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
    end
  end

  a_mul_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MUL |-> cnt_q <= 10'd6)
    else $error("multiply step out of range");

  a_done_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !sts_i.out_busy) |=> state_q == S_IDLE)
    else $error("result not issued");

  a_load_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i && in_op_i == vna_pkg::OP_LOAD) |=> state_q == S_LOAD)
    else $error("load word not dispatched");

endmodule

`default_nettype wire

FILE: design/vertex_normal_accumulator_core.sv
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_core
// Smooth per-vertex normals from face cross products, normalized on read.
// ----------------------------------------------------------------------------
// Load: capture, then vertex store write. Triangle and quad: four position reads,
// seven multiply steps, then an accumulator read-modify-write per corner.
// Read: an all-zero sum is output as zero; otherwise a range shift (0..33
// steps), a square root (32 steps) and three 18-step divisions on one shared
// divider produce the result. One word at a time.
// After reset every accumulator RAM slot is cleared in turn; no word is
// taken during that pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vertex_normal_accumulator_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output      logic                       s_axis_tready,
  // vertex_slot, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c, corner_d, zero pad
  input  wire logic [vna_pkg::IN_W-1:0]   s_axis_tdata,
  // op
  input  wire logic [1:0]                 s_axis_tuser,
  output      logic                       m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // normal_slot, norm_x, norm_y, norm_z, zero pad
  output      logic [vna_pkg::OUT_W-1:0]  m_axis_tdata
);

  vna_pkg::dp_cmd_t cmd;
  vna_pkg::dp_sts_t sts;

  vna_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  vna_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .in_op_i     (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire
